### design/tsw_pkg.sv
`default_nettype none
package tsw_pkg;

  localparam int CoordBits = 24;
  localparam int FracBits  = 16;
  localparam int ChanBits  = 16;
  localparam int DimBits   = 9;

  typedef enum logic [1:0] {
    BORDER_CLAMP  = 2'd0,
    BORDER_MIRROR = 2'd1,
    BORDER_REPEAT = 2'd2,
    BORDER_ALT    = 2'd3
  } border_e;

  typedef enum logic [1:0] {
    REG_BORDER = 2'd0,
    REG_FILTER = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_e;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                        command;
    logic signed [CoordBits-1:0] coord_u;
    logic signed [CoordBits-1:0] coord_v;
    logic [7:0]                  texel_x;
    logic [7:0]                  texel_y;
    logic [ChanBits-1:0]         texel_red;
    logic [ChanBits-1:0]         texel_green;
    logic [ChanBits-1:0]         texel_blue;
  } in_item_t;

  typedef struct packed {
    logic [ChanBits-1:0] out_red;
    logic [ChanBits-1:0] out_green;
    logic [ChanBits-1:0] out_blue;
  } out_item_t;

  // Register values after clamping, shared by the address stage.
  typedef struct packed {
    logic [1:0]         border;
    logic               filter;
    logic [DimBits-1:0] width;
    logic [DimBits-1:0] height;
  } cfg_t;

endpackage
`default_nettype wire

### design/tsw_coord.sv
`default_nettype none
// Folds one coordinate with the border mode and forms the texel index and weight.
// Stage A: fold and scale multiply, registered. Stage B: index clamp, registered.
module tsw_coord (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [1:0]                           border_i,
  input  wire logic                                 filter_i,
  input  wire logic [8:0]                           dim_i,
  input  wire logic signed [tsw_pkg::CoordBits-1:0] coord_i,
  output logic [7:0]                                idx0_o,
  output logic [7:0]                                idx1_o,
  output logic [tsw_pkg::FracBits-1:0]              weight_o
);
  import tsw_pkg::*;

  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  logic [FracBits:0]   t_fold;
  logic [FracBits:0]   t_use;
  logic [8:0]          scale;
  logic [FracBits+9:0] prod_d, prod_q;
  logic [8:0]          dim_q;
  logic                filter_q;
  logic [FracBits-1:0] frac;
  logic                odd;

  // Border folding into [0, one].
  always_comb begin
    frac = coord_i[FracBits-1:0];
    odd  = coord_i[FracBits];
    case (border_e'(border_i))
      BORDER_CLAMP: begin
        if (coord_i[CoordBits-1]) t_fold = '0;
        else if ($signed(coord_i) > $signed({{(CoordBits-1-FracBits){1'b0}}, One}))
          t_fold = One;
        else t_fold = coord_i[FracBits:0];
      end
      BORDER_MIRROR: t_fold = odd ? (One - {1'b0, frac}) : {1'b0, frac};
      default:       t_fold = {1'b0, frac};
    endcase
    if (filter_i) begin
      t_use = t_fold[FracBits] ? {1'b0, {FracBits{1'b1}}} : t_fold;
      scale = dim_i - 9'd1;
    end else begin
      t_use = t_fold;
      scale = dim_i;
    end
    prod_d = {{9{1'b0}}, t_use} * {{(FracBits+1){1'b0}}, scale};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      dim_q    <= dim_i;
      filter_q <= filter_i;
    end
  end

  // Index clamp and neighbour; nearest mode reads a single texel.
  logic [9:0] ip;
  logic [8:0] lim;
  logic [8:0] i0;
  logic [8:0] i1;
  always_comb begin
    ip  = prod_q[FracBits+9:FracBits];
    lim = dim_q - 9'd1;
    i0  = (ip > {1'b0, lim}) ? lim : ip[8:0];
    if (!filter_q) i1 = i0;
    else if (i0 + 9'd1 > lim) i1 = lim;
    else i1 = i0 + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx0_o   <= i0[7:0];
      idx1_o   <= i1[7:0];
      weight_o <= filter_q ? prod_q[FracBits-1:0] : '0;
    end
  end
endmodule
`default_nettype wire

### design/tsw_bank.sv
`default_nettype none
// One texel bank holding the texels of one x and y parity.
module tsw_bank (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [13:0] waddr_i,
  input  wire logic [47:0] wdata_i,
  input  wire logic        re_i,
  input  wire logic [13:0] raddr_i,
  output logic [47:0]      rdata_o
);
  import tsw_pkg::*;

  logic [47:0] mem [16384];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### design/tsw_lerp.sv
`default_nettype none
// Registered blend of two channels with a Q0.16 weight.
module tsw_lerp (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] a_i,
  input  wire logic [15:0] b_i,
  input  wire logic [15:0] l_i,
  output logic [15:0]      y_o
);
  import tsw_pkg::*;

  logic [16:0] il;
  logic [33:0] sum;

  always_comb begin
    il  = 17'h10000 - {1'b0, l_i};
    sum = {1'b0, il} * {17'd0, a_i} + {18'd0, l_i} * {18'd0, b_i} + 34'h8000;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) y_o <= sum[31:16];
  end
endmodule
`default_nettype wire

### design/texture_sampler_wrap_bilinear.sv
`default_nettype none
// Five register stages: fold and scale, index clamp, bank read, horizontal blend and vertical blend.
// Throughput: one item per cycle while the output is not stalled; the four parity banks give four reads a cycle.
// Writes pass through the wr1 and wr2 registers to reach the store in step with reads, and give no result.
// Reset clears valid bits and restores the registers; texel contents are undefined.
// Stall holds the whole pipeline; the input stays open while no result waits.
module texture_sampler_wrap_bilinear (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire tsw_pkg::in_item_t    in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output tsw_pkg::out_item_t        out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);
  import tsw_pkg::*;

  localparam int Stages = 5;

  cfg_t cfg;
  logic [1:0] border_q;
  logic       filter_q;
  logic [8:0] w_raw_q, h_raw_q;
  logic [Stages-1:0] vld_q;
  logic en;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= BORDER_REPEAT;
      filter_q <= 1'b0;
      w_raw_q  <= 9'd256;
      h_raw_q  <= 9'd256;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_BORDER: border_q <= cfg_data_i[1:0];
        REG_FILTER: filter_q <= cfg_data_i[0];
        REG_WIDTH:  w_raw_q  <= cfg_data_i[8:0];
        REG_HEIGHT: h_raw_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Width and height limited to one through the store size.
  always_comb begin
    cfg.border = border_q;
    cfg.filter = filter_q;
    cfg.width  = (w_raw_q == '0) ? 9'd1 : ((w_raw_q > 9'd256) ? 9'd256 : w_raw_q);
    cfg.height = (h_raw_q == '0) ? 9'd1 : ((h_raw_q > 9'd256) ? 9'd256 : h_raw_q);
  end

  // Pipeline advances unless a result waits on a stalled output.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic accept, sample_in;
  assign accept    = in_valid_i && en;
  assign sample_in = accept && (in_item_i.command == CMD_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Stages-2:0], sample_in};
  end
  assign out_valid_o = vld_q[Stages-1];

  // Coordinate units, two stages.
  logic [7:0] x0, x1, y0, y1;
  logic [15:0] lu, lv;
  logic [1:0]  border_b;
  assign border_b = (cfg.border == BORDER_ALT) ? BORDER_REPEAT : cfg.border;

  tsw_coord u_cu (
    .clk_i, .en_i(en), .border_i(border_b), .filter_i(cfg.filter),
    .dim_i(cfg.width), .coord_i(in_item_i.coord_u),
    .idx0_o(x0), .idx1_o(x1), .weight_o(lu)
  );
  tsw_coord u_cv (
    .clk_i, .en_i(en), .border_i(border_b), .filter_i(cfg.filter),
    .dim_i(cfg.height), .coord_i(in_item_i.coord_v),
    .idx0_o(y0), .idx1_o(y1), .weight_o(lv)
  );

  // Weights ride along to the blend stages.
  logic [15:0] lu_q, lv_q, lv_q2;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lu_q  <= lu;
      lv_q  <= lv;
      lv_q2 <= lv_q;
    end
  end

  // Bank read addresses: bank (py,px) holds texels of that parity.
  logic [7:0] xe, xo, ye, yo;
  logic       x0_odd, y0_odd;
  logic       x0_odd_q, y0_odd_q, same_x_q, same_y_q;
  assign x0_odd = x0[0];
  assign y0_odd = y0[0];
  assign xe = x0_odd ? x1 : x0;
  assign xo = x0_odd ? x0 : x1;
  assign ye = y0_odd ? y1 : y0;
  assign yo = y0_odd ? y0 : y1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_odd_q <= x0_odd;
      y0_odd_q <= y0_odd;
      same_x_q <= (x0 == x1);
      same_y_q <= (y0 == y1);
    end
  end

  logic write_in;
  logic [1:0] wbank;
  logic [13:0] waddr;
  assign write_in = accept && (in_item_i.command == CMD_WRITE);
  assign wbank    = {in_item_i.texel_y[0], in_item_i.texel_x[0]};
  assign waddr    = {in_item_i.texel_y[7:1], in_item_i.texel_x[7:1]};

  // Writes travel two stages so that they reach the store in item order with the reads.
  logic        wr1_q, wr2_q;
  logic [1:0]  wb1_q, wb2_q;
  logic [13:0] wa1_q, wa2_q;
  logic [47:0] wd1_q, wd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr1_q <= 1'b0;
      wr2_q <= 1'b0;
    end else if (en) begin
      wr1_q <= write_in;
      wr2_q <= wr1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wb1_q <= wbank;
      wa1_q <= waddr;
      wd1_q <= {in_item_i.texel_red, in_item_i.texel_green, in_item_i.texel_blue};
      wb2_q <= wb1_q;
      wa2_q <= wa1_q;
      wd2_q <= wd1_q;
    end
  end

  logic [47:0] rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0] bx, by;
    assign bx = ((b & 1) != 0) ? xo : xe;
    assign by = ((b & 2) != 0) ? yo : ye;
    tsw_bank u_bank (
      .clk_i,
      .we_i(en && wr2_q && (wb2_q == 2'(b))),
      .waddr_i(wa2_q),
      .wdata_i(wd2_q),
      .re_i(en),
      .raddr_i({by[7:1], bx[7:1]}),
      .rdata_o(rd[b])
    );
  end

  // Pick the four corners; a clamped neighbour reuses its own corner.
  logic [47:0] c00, c01, c10, c11;
  always_comb begin
    logic [1:0] b00, b01, b10, b11;
    b00 = {y0_odd_q, x0_odd_q};
    b01 = {y0_odd_q, same_x_q ? x0_odd_q : !x0_odd_q};
    b10 = {same_y_q ? y0_odd_q : !y0_odd_q, x0_odd_q};
    b11 = {same_y_q ? y0_odd_q : !y0_odd_q, same_x_q ? x0_odd_q : !x0_odd_q};
    c00 = rd[b00];
    c01 = rd[b01];
    c10 = rd[b10];
    c11 = rd[b11];
  end

  // Horizontal then vertical blend, one register each.
  logic [15:0] r0 [3];
  logic [15:0] r1 [3];
  logic [15:0] fo [3];
  for (genvar c = 0; c < 3; c++) begin : g_ch
    tsw_lerp u_h0 (.clk_i, .en_i(en), .a_i(c00[16*c +: 16]), .b_i(c01[16*c +: 16]),
                   .l_i(lu_q), .y_o(r0[c]));
    tsw_lerp u_h1 (.clk_i, .en_i(en), .a_i(c10[16*c +: 16]), .b_i(c11[16*c +: 16]),
                   .l_i(lu_q), .y_o(r1[c]));
    tsw_lerp u_v  (.clk_i, .en_i(en), .a_i(r0[c]), .b_i(r1[c]),
                   .l_i(lv_q2), .y_o(fo[c]));
  end

  // Blue is the lowest slice of the stored word.
  assign out_item_o.out_blue  = fo[0];
  assign out_item_o.out_green = fo[1];
  assign out_item_o.out_red   = fo[2];

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("held result changed");
  // The input is stalled exactly when the output holds a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall mismatch");
  // A sample taken in is marked valid in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_in |=> vld_q[0])
    else $error("sample lost at entry");
endmodule
`default_nettype wire

### dv/texture_sampler_wrap_bilinear_tb.sv
`timescale 1ns / 100ps

module texture_sampler_wrap_bilinear_tb;
  import tsw_pkg::*;

  localparam int unsigned OneFx     = 65536;
  localparam int          DrainGap  = 12;
  localparam int          StallLimit = 3000;
  localparam int          HoldCycles = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  texture_sampler_wrap_bilinear u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predictor state: the texel store, which texels hold data, and the registers.
  logic [47:0] texel_mem [65536];
  bit          texel_written [65536];
  logic [1:0]  border_reg;
  logic        filter_reg;
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;

  out_item_t   colour_queue [$];
  int          error_count;
  bit          idle_en;
  bit          hold_req;
  int          quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, exp_val);
    error_count++;
  endtask

  function automatic int unsigned eff_dim(input logic [8:0] d);
    if (d == 0) return 1;
    if (d > 256) return 256;
    return d;
  endfunction

  // Fold one signed coordinate into [0, ONE] according to the border mode.
  function automatic longint fold_coord(input logic signed [23:0] c);
    longint cl;
    longint frac;
    longint ip;
    cl = c;
    frac = cl & (OneFx - 1);
    ip = (cl - frac) >>> 16;
    if (border_reg == BORDER_CLAMP) begin
      if (cl < 0) return 0;
      if (cl > OneFx) return OneFx;
      return cl;
    end
    if (border_reg == BORDER_MIRROR && ip[0]) return OneFx - frac;
    return frac;
  endfunction

  // Work out the texels a sample reads and the blend weights.
  function automatic void locate_texels(input logic signed [23:0] u, input logic signed [23:0] v,
                                        output int x0, output int x1, output int y0,
                                        output int y1, output longint lu, output longint lv);
    longint tu;
    longint tv;
    longint w;
    longint h;
    longint pu;
    longint pv;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    tu = fold_coord(u);
    tv = fold_coord(v);
    if (filter_reg == 1'b0) begin
      x0 = ((tu * w) >> 16) > w - 1 ? w - 1 : (tu * w) >> 16;
      y0 = ((tv * h) >> 16) > h - 1 ? h - 1 : (tv * h) >> 16;
      x1 = x0;
      y1 = y0;
      lu = 0;
      lv = 0;
    end else begin
      if (tu > OneFx - 1) tu = OneFx - 1;
      if (tv > OneFx - 1) tv = OneFx - 1;
      pu = tu * (w - 1);
      pv = tv * (h - 1);
      x0 = pu >> 16;
      y0 = pv >> 16;
      lu = pu & (OneFx - 1);
      lv = pv & (OneFx - 1);
      x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
      y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
    end
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint l);
    return ((OneFx - l) * a + l * b + OneFx / 2) >> 16;
  endfunction

  // Expected colour of one sample.
  function automatic out_item_t predict_colour(input in_item_t it);
    int x0, x1, y0, y1;
    longint lu, lv;
    logic [47:0] t00, t01, t10, t11;
    longint r0, r1;
    out_item_t res;
    locate_texels(it.coord_u, it.coord_v, x0, x1, y0, y1, lu, lv);
    t00 = texel_mem[y0 * 256 + x0];
    t01 = texel_mem[y0 * 256 + x1];
    t10 = texel_mem[y1 * 256 + x0];
    t11 = texel_mem[y1 * 256 + x1];
    if (filter_reg == 1'b0) return t00;
    for (int ch = 0; ch < 3; ch++) begin
      r0 = blend(t00[47 - 16 * ch -: 16], t01[47 - 16 * ch -: 16], lu);
      r1 = blend(t10[47 - 16 * ch -: 16], t11[47 - 16 * ch -: 16], lu);
      res[47 - 16 * ch -: 16] = 16'(blend(r0, r1, lv));
    end
    return res;
  endfunction

  // Offer one item, wait for it to be taken, then update the predictor.
  task automatic send_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.command == CMD_WRITE) begin
      texel_mem[{it.texel_y, it.texel_x}]     = {it.texel_red, it.texel_green, it.texel_blue};
      texel_written[{it.texel_y, it.texel_x}] = 1'b1;
    end else begin
      colour_queue.push_back(predict_colour(it));
    end
  endtask

  function automatic in_item_t random_item(input logic cmd);
    in_item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  task automatic write_texel(input int x, input int y);
    in_item_t it;
    it = random_item(CMD_WRITE);
    it.texel_x = 8'(x);
    it.texel_y = 8'(y);
    send_item(it);
  endtask

  // Sample, first writing any texel that the sample would read unwritten.
  task automatic sample_at(input logic signed [23:0] u, input logic signed [23:0] v);
    int x0, x1, y0, y1;
    longint lu, lv;
    in_item_t it;
    locate_texels(u, v, x0, x1, y0, y1, lu, lv);
    if (!texel_written[y0 * 256 + x0]) write_texel(x0, y0);
    if (!texel_written[y0 * 256 + x1]) write_texel(x1, y0);
    if (!texel_written[y1 * 256 + x0]) write_texel(x0, y1);
    if (!texel_written[y1 * 256 + x1]) write_texel(x1, y1);
    it = random_item(CMD_SAMPLE);
    it.coord_u = u;
    it.coord_v = v;
    send_item(it);
  endtask

  // Let every outstanding result arrive and the pipeline empty.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (colour_queue.size() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [8:0] value, input logic [31:0] mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= ($urandom & ~mask) | {23'd0, value};
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BORDER: border_reg = value[1:0];
      REG_FILTER: filter_reg = value[0];
      REG_WIDTH:  width_reg  = value;
      default:    height_reg = value;
    endcase
  endtask

  // Reprogram all four registers while the block is idle.
  task automatic set_mode(input logic [1:0] border, input logic filter,
                          input logic [8:0] w, input logic [8:0] h);
    drain_block();
    write_reg(REG_BORDER, {7'd0, border}, 32'h3);
    write_reg(REG_FILTER, {8'd0, filter}, 32'h1);
    write_reg(REG_WIDTH, w, 32'h1ff);
    write_reg(REG_HEIGHT, h, 32'h1ff);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] random_coord();
    if ($urandom_range(0, 2) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(0, 6 * OneFx)) - 3 * OneFx);
  endfunction

  function automatic logic [8:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      3:       return 9'd1;
      default: return 9'($urandom_range(2, 16));
    endcase
  endfunction

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) send_item(random_item(CMD_WRITE));
      else sample_at(random_coord(), random_coord());
    end
  endtask

  // Samples under the register values left by reset.
  task automatic test_reset_defaults();
    sample_at(24'sh000000, 24'sh000000);
    sample_at(24'sh7fffff, 24'sh800000);
  endtask

  // Coordinate extremes and the register corner cases.
  task automatic test_directed_corners();
    set_mode(BORDER_CLAMP, 1'b1, 9'd4, 9'd4);
    sample_at(24'sh800000, 24'sh7fffff);
    sample_at(24'sh010000, 24'sh00ffff);
    sample_at(24'shffffff, 24'sh008000);
    set_mode(BORDER_MIRROR, 1'b0, 9'd0, 9'd511);
    sample_at(24'shff0000, 24'sh018000);
    sample_at(24'sh7fffff, 24'shfe8000);
    set_mode(BORDER_ALT, 1'b1, 9'd256, 9'd1);
    sample_at(24'sh00ffff, 24'sh800000);
    sample_at(24'sh018000, 24'sh7fffff);
    set_mode(BORDER_REPEAT, 1'b0, 9'd3, 9'd2);
    sample_at(24'sh010000, 24'shffffff);
  endtask

  // Random content under random register settings.
  task automatic test_random_modes();
    for (int phase = 0; phase < 9; phase++) begin
      set_mode(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), random_dim(),
               random_dim());
      random_burst(25);
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_mode(BORDER_MIRROR, 1'b1, 9'd8, 9'd8);
    hold_req = 1'b1;
    random_burst(40);
  endtask

  // Closing stretch with neither side idling.
  task automatic test_full_rate();
    set_mode(BORDER_REPEAT, 1'b1, 9'd16, 9'd16);
    idle_en = 1'b0;
    random_burst(60);
  endtask

  // Receiver stall: random short bursts, and one long hold-off when asked.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest expected colour.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (colour_queue.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item_o), 0);
      end else begin
        want = colour_queue.pop_front();
        if (out_item_o.out_red !== want.out_red)
          report_mismatch("out_red", out_item_o.out_red, want.out_red);
        if (out_item_o.out_green !== want.out_green)
          report_mismatch("out_green", out_item_o.out_green, want.out_green);
        if (out_item_o.out_blue !== want.out_blue)
          report_mismatch("out_blue", out_item_o.out_blue, want.out_blue);
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_BORDER;
    cfg_data_i  = '0;
    error_count = 0;
    quiet_cycles = 0;
    idle_en     = 1'b1;
    hold_req    = 1'b0;
    border_reg  = BORDER_REPEAT;
    filter_reg  = 1'b0;
    width_reg   = 9'd256;
    height_reg  = 9'd256;
    repeat (10) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_corners();
    test_random_modes();
    test_backpressure();
    test_full_rate();
    drain_block();
    repeat (DrainGap) @(posedge clk_i);

    if (error_count == 0 && colour_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### texture_sampler_wrap_bilinear.f
design/tsw_pkg.sv
design/tsw_coord.sv
design/tsw_bank.sv
design/tsw_lerp.sv
design/texture_sampler_wrap_bilinear.sv
dv/texture_sampler_wrap_bilinear_tb.sv
